// ===== rtl/rgbc_pkg.sv =====
// Shared types, constants and kernel coefficients for the RGB 3x3 convolution block.
package rgbc_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int OUT_DEPTH_DEF = 8;

  // Window geometry
  localparam int KERNEL_DIM = 3;
  localparam int KERNEL_CTR = KERNEL_DIM / 2;
  localparam int DIM_MIN    = 3;

  // Pixel and field widths
  localparam int CH_W      = 8;
  localparam int CH_MAX    = 255;
  localparam int PIX_W     = 3 * CH_W;
  localparam int OUT_COL_W = 10;
  localparam int ROW_W     = 12;

  // Configuration port
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 12;
  localparam int KSEL_W       = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 12;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SELECT = 2'd2;

  localparam logic [KSEL_W-1:0] KSEL_EDGE    = 2'd0;
  localparam logic [KSEL_W-1:0] KSEL_SHARPEN = 2'd1;
  localparam logic [KSEL_W-1:0] KSEL_BLUR    = 2'd2;

  localparam logic [WIDTH_REG_W-1:0]  IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] IMAGE_HEIGHT_RST = 12'd480;
  localparam logic [KSEL_W-1:0]       KSEL_RST         = KSEL_EDGE;

  // Arithmetic widths: box sum of nine bytes, signed kernel sum, blur scale in Q0.16
  localparam int BSUM_W      = 12;
  localparam int FSUM_W      = 13;
  localparam int COEF_W      = 5;
  localparam int BLUR_COEF_W = 13;
  localparam int BLUR_SHIFT  = 16;
  localparam logic [BLUR_COEF_W-1:0] BLUR_COEF = 13'd7281;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  // Window indexed [row][col]; row 0 is the oldest line, col 0 the oldest column
  typedef pixel_t [KERNEL_DIM-1:0][KERNEL_DIM-1:0] window_t;

  typedef struct packed {
    logic [OUT_COL_W-1:0] col;
    logic [ROW_W-1:0]     row;
    logic                 last;
  } tag_t;

  typedef struct packed {
    pixel_t pix;
    tag_t   tag;
  } result_t;

  // Stage control: vld marks a word in the stage, res marks one that yields a result
  typedef struct packed {
    logic vld;
    logic res;
  } stage_ctl_t;

  // Kernel tap; unused selector codes fall back to edge detect
  function automatic coef_t kernel_coef(input logic [KSEL_W-1:0] ksel, input int i,
                                        input int j);
    coef_t c;
    logic  centre;
    logic  direct;
    centre = (i == KERNEL_CTR) && (j == KERNEL_CTR);
    direct = (i == KERNEL_CTR) != (j == KERNEL_CTR);
    case (ksel)
      KSEL_SHARPEN: c = centre ? 5'sd5 : (direct ? -5'sd1 : 5'sd0);
      default:      c = centre ? 5'sd8 : -5'sd1;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/rgbc_if.sv =====
// Valid/ready stream interfaces for incoming pixels and filtered results.
interface rgbc_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [rgbc_pkg::CH_W-1:0] in_red;
  logic [rgbc_pkg::CH_W-1:0] in_green;
  logic [rgbc_pkg::CH_W-1:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue, input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

interface rgbc_result_if;
  logic                           valid;
  logic                           ready;
  logic [rgbc_pkg::CH_W-1:0]      out_red;
  logic [rgbc_pkg::CH_W-1:0]      out_green;
  logic [rgbc_pkg::CH_W-1:0]      out_blue;
  logic [rgbc_pkg::OUT_COL_W-1:0] out_col;
  logic [rgbc_pkg::ROW_W-1:0]     out_row;
  logic                           frame_last;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_col, output out_row, output frame_last, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input out_col, input out_row, input frame_last, output ready);
endinterface

// ===== rtl/rgbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rgbc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rgbc_line_buf.sv =====
// Line stores, raster counters and the 3x3 pixel window.
module rgbc_line_buf #(
  parameter int MAX_WIDTH = rgbc_pkg::MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         acc,
  input  rgbc_pkg::pixel_t             pix,
  input  logic                         geo_clear,
  input  logic [CW-1:0]                w_last,
  input  logic [rgbc_pkg::ROW_W-1:0]   h_last,
  output rgbc_pkg::stage_ctl_t         s1_ctl,
  output rgbc_pkg::window_t            win,
  output rgbc_pkg::stage_ctl_t         win_ctl,
  output rgbc_pkg::tag_t               win_tag
);

  localparam int LAST_ROW = rgbc_pkg::KERNEL_DIM - 1;
  localparam int LAST_COL = rgbc_pkg::KERNEL_DIM - 1;

  logic [CW-1:0]                col;
  logic [rgbc_pkg::ROW_W-1:0]   row;
  logic                         col_wrap;
  logic                         row_wrap;
  logic                         has_res;

  logic [CW-1:0]                s1_col;
  rgbc_pkg::pixel_t             s1_pix;
  rgbc_pkg::tag_t               s1_tag;

  logic [rgbc_pkg::PIX_W-1:0]   top_rd;
  logic [rgbc_pkg::PIX_W-1:0]   mid_rd;

  assign col_wrap = (col >= w_last);
  assign row_wrap = (row >= h_last);
  assign has_res  = (row >= rgbc_pkg::ROW_W'(2)) && (col >= CW'(2));

  // Advance column and row per accepted word; a geometry write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (geo_clear) begin
      col <= '0;
      row <= '0;
    end else if (acc) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // Stage 1: hold the word while both line stores are read at its column
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl.vld <= acc;
      s1_ctl.res <= acc && has_res;
    end
  end

  always_ff @(posedge clk) begin
    s1_col      <= col;
    s1_pix      <= pix;
    s1_tag.col  <= rgbc_pkg::OUT_COL_W'(col - CW'(1));
    s1_tag.row  <= row - 1'b1;
    s1_tag.last <= row_wrap && col_wrap;
  end

  // Newest line store: read the previous row, write the incoming pixel back
  rgbc_ram #(
    .WIDTH (rgbc_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_a (
    .clk   (clk),
    .we    (s1_ctl.vld),
    .waddr (s1_col),
    .wdata (s1_pix),
    .re    (acc),
    .raddr (col),
    .rdata (mid_rd)
  );

  // Older line store: read two rows up, write back what the newer store held
  rgbc_ram #(
    .WIDTH (rgbc_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_b (
    .clk   (clk),
    .we    (s1_ctl.vld),
    .waddr (s1_col),
    .wdata (mid_rd),
    .re    (acc),
    .raddr (col),
    .rdata (top_rd)
  );

  // Shift the window one column and load the new right-hand column
  always_ff @(posedge clk) begin
    if (s1_ctl.vld) begin
      for (int i = 0; i < rgbc_pkg::KERNEL_DIM; i++) begin
        for (int j = 0; j < LAST_COL; j++) begin
          win[i][j] <= win[i][j+1];
        end
      end
      win[0][LAST_COL]        <= rgbc_pkg::pixel_t'(top_rd);
      win[1][LAST_COL]        <= rgbc_pkg::pixel_t'(mid_rd);
      win[LAST_ROW][LAST_COL] <= s1_pix;
    end
    win_tag <= s1_tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_ctl <= '0;
    end else begin
      win_ctl <= s1_ctl;
    end
  end

  // A new read never hits the column still being written back
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (acc && s1_ctl.vld && !$past(geo_clear)) |-> (col != s1_col))
    else $error("line store read collides with pending write-back");

  // Column counter stays inside the active row
  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (col <= w_last))
    else $error("column counter ran past the row end");

endmodule

// ===== rtl/rgbc_filter.sv =====
// Kernel datapath: tap sums per channel, then blur scaling and clamping.
module rgbc_filter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rgbc_pkg::KSEL_W-1:0] ksel,
  input  rgbc_pkg::window_t           win,
  input  rgbc_pkg::stage_ctl_t        win_ctl,
  input  rgbc_pkg::tag_t              win_tag,
  output logic                        sum_res,
  output logic                        push,
  output rgbc_pkg::result_t           push_data
);

  localparam int NCH    = 3;
  localparam int PROD_W = rgbc_pkg::BSUM_W + rgbc_pkg::BLUR_COEF_W;
  localparam int BQ_W   = PROD_W - rgbc_pkg::BLUR_SHIFT;

  logic        [rgbc_pkg::BSUM_W-1:0] bsum   [NCH];
  logic signed [rgbc_pkg::FSUM_W-1:0] ksum   [NCH];
  logic        [rgbc_pkg::BSUM_W-1:0] s_bsum [NCH];
  logic signed [rgbc_pkg::FSUM_W-1:0] s_ksum [NCH];
  rgbc_pkg::stage_ctl_t               s_ctl;
  rgbc_pkg::tag_t                     s_tag;
  logic        [rgbc_pkg::CH_W-1:0]   chan   [NCH];

  function automatic logic [rgbc_pkg::CH_W-1:0] pix_chan(input rgbc_pkg::pixel_t p,
                                                          input int k);
    logic [rgbc_pkg::CH_W-1:0] v;
    case (k)
      0:       v = p.red;
      1:       v = p.green;
      default: v = p.blue;
    endcase
    return v;
  endfunction

  // Sum the nine taps per channel, plain and kernel-weighted
  always_comb begin
    logic        [rgbc_pkg::CH_W-1:0]   px;
    logic signed [rgbc_pkg::FSUM_W-1:0] coef_s;
    logic signed [rgbc_pkg::FSUM_W-1:0] px_s;
    for (int k = 0; k < NCH; k++) begin
      bsum[k] = '0;
      ksum[k] = '0;
      for (int i = 0; i < rgbc_pkg::KERNEL_DIM; i++) begin
        for (int j = 0; j < rgbc_pkg::KERNEL_DIM; j++) begin
          px      = pix_chan(win[i][j], k);
          coef_s  = rgbc_pkg::FSUM_W'(rgbc_pkg::kernel_coef(ksel, i, j));
          px_s    = $signed(rgbc_pkg::FSUM_W'(px));
          bsum[k] = bsum[k] + rgbc_pkg::BSUM_W'(px);
          ksum[k] = ksum[k] + coef_s * px_s;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_ctl <= '0;
    end else begin
      s_ctl <= win_ctl;
    end
  end

  always_ff @(posedge clk) begin
    s_bsum <= bsum;
    s_ksum <= ksum;
    s_tag  <= win_tag;
  end

  // Scale the box sum or clamp the kernel sum into a byte
  always_comb begin
    logic [PROD_W-1:0] prod;
    logic [BQ_W-1:0]   blur_q;
    for (int k = 0; k < NCH; k++) begin
      prod   = PROD_W'(s_bsum[k]) * PROD_W'(rgbc_pkg::BLUR_COEF);
      blur_q = prod[PROD_W-1:rgbc_pkg::BLUR_SHIFT];
      if (ksel == rgbc_pkg::KSEL_BLUR) begin
        chan[k] = (blur_q > BQ_W'(rgbc_pkg::CH_MAX)) ? rgbc_pkg::CH_W'(rgbc_pkg::CH_MAX)
                                                      : rgbc_pkg::CH_W'(blur_q);
      end else if (s_ksum[k][rgbc_pkg::FSUM_W-1]) begin
        chan[k] = '0;
      end else if (s_ksum[k] > rgbc_pkg::FSUM_W'(rgbc_pkg::CH_MAX)) begin
        chan[k] = rgbc_pkg::CH_W'(rgbc_pkg::CH_MAX);
      end else begin
        chan[k] = rgbc_pkg::CH_W'(s_ksum[k]);
      end
    end
  end

  assign sum_res             = s_ctl.res;
  assign push                = s_ctl.vld && s_ctl.res;
  assign push_data.pix.red   = chan[0];
  assign push_data.pix.green = chan[1];
  assign push_data.pix.blue  = chan[2];
  assign push_data.tag       = s_tag;

endmodule

// ===== rtl/rgbc_out_fifo.sv =====
// Result queue that decouples the filter pipeline from the output handshake.
module rgbc_out_fifo #(
  parameter int DEPTH = rgbc_pkg::OUT_DEPTH_DEF,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rgbc_pkg::result_t wdata,
  input  logic              pop,
  output rgbc_pkg::result_t rdata,
  output logic              nonempty,
  output logic [CNT_W-1:0]  count
);

  rgbc_pkg::result_t mem [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign rdata    = mem[rd_ptr];
  assign nonempty = (count != '0);

  // Admission control must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != CNT_W'(DEPTH)))
    else $error("result queue written while full");

endmodule

// ===== rtl/rgb_convolution_3x3_top.sv =====
// Top level of the streaming RGB 3x3 convolution block.
//
// Pixels enter on the pixel channel (valid/ready) in raster order, one word per
// accepted handshake; filtered interior pixels leave on the result channel with
// their column, row and an end-of-frame flag. Border pixels produce no word.
// The user must write registers via cfg_we/cfg_index/cfg_data while the block is
// idle (not enforced); width or height writes restart the frame at row 0, column 0.
//
// Throughput: one pixel per clock while pixel ready is high. Each pixel reads both
// line stores at its column once and writes them back the next cycle, so one read
// and one write port per store set the rate.
// Path: a result passes the stage-1, window and sum registers before it enters the
// output queue, and can be taken on the following cycle.
// Reset: counters and registers take their defaults (640 x 480, edge detect).
// Line stores are not cleared; the first two rows of a frame fill them before
// any result depends on them.
// Stall: results wait in an OUT_DEPTH-entry queue; pixel ready drops while the
// queue plus the results still in the pipeline would fill it, so nothing is lost.
module rgb_convolution_3x3_top #(
  parameter int MAX_WIDTH = rgbc_pkg::MAX_WIDTH_DEF,
  parameter int OUT_DEPTH = rgbc_pkg::OUT_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rgbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbc_pkg::CFG_DATA_W-1:0] cfg_data,
  rgbc_pixel_if.sink                      pixel,
  rgbc_result_if.source                   result
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int MW_W  = $clog2(MAX_WIDTH + 1);
  localparam int LW    = (MW_W > rgbc_pkg::WIDTH_REG_W) ? MW_W : rgbc_pkg::WIDTH_REG_W;
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int SUM_W = CNT_W + 2;

  logic [rgbc_pkg::WIDTH_REG_W-1:0]  image_width;
  logic [rgbc_pkg::HEIGHT_REG_W-1:0] image_height;
  logic [rgbc_pkg::KSEL_W-1:0]       kernel_select;

  logic                       geo_clear;
  logic [LW-1:0]              w_eff;
  logic [CW-1:0]              w_last;
  logic [rgbc_pkg::ROW_W-1:0] h_last;

  logic                 acc;
  rgbc_pkg::pixel_t     in_pix;
  rgbc_pkg::stage_ctl_t s1_ctl;
  rgbc_pkg::window_t    win;
  rgbc_pkg::stage_ctl_t win_ctl;
  rgbc_pkg::tag_t       win_tag;
  logic                 sum_res;
  logic                 push;
  rgbc_pkg::result_t    push_data;
  rgbc_pkg::result_t    q_data;
  logic                 q_nonempty;
  logic [CNT_W-1:0]     q_count;
  logic                 pop;
  logic [SUM_W-1:0]     pending;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= rgbc_pkg::IMAGE_WIDTH_RST;
      image_height  <= rgbc_pkg::IMAGE_HEIGHT_RST;
      kernel_select <= rgbc_pkg::KSEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rgbc_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data[rgbc_pkg::WIDTH_REG_W-1:0];
        rgbc_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data[rgbc_pkg::HEIGHT_REG_W-1:0];
        rgbc_pkg::REG_KERNEL_SELECT: kernel_select <= cfg_data[rgbc_pkg::KSEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign geo_clear = cfg_we && ((cfg_index == rgbc_pkg::REG_IMAGE_WIDTH) ||
                                (cfg_index == rgbc_pkg::REG_IMAGE_HEIGHT));

  // Clamp the geometry to the supported range and form the last column and row
  always_comb begin
    if (image_width < rgbc_pkg::WIDTH_REG_W'(rgbc_pkg::DIM_MIN)) begin
      w_eff = LW'(rgbc_pkg::DIM_MIN);
    end else if (LW'(image_width) > LW'(MAX_WIDTH)) begin
      w_eff = LW'(MAX_WIDTH);
    end else begin
      w_eff = LW'(image_width);
    end
    w_last = CW'(w_eff - LW'(1));
    if (image_height < rgbc_pkg::HEIGHT_REG_W'(rgbc_pkg::DIM_MIN)) begin
      h_last = rgbc_pkg::ROW_W'(rgbc_pkg::DIM_MIN - 1);
    end else begin
      h_last = image_height - 1'b1;
    end
  end

  // Admit a pixel only while its possible result has a free queue slot
  assign pending = SUM_W'(q_count) + SUM_W'(s1_ctl.res) + SUM_W'(win_ctl.res) +
                   SUM_W'(sum_res);
  assign pixel.ready = (pending < SUM_W'(OUT_DEPTH));
  assign acc         = pixel.valid && pixel.ready;

  always_comb begin
    in_pix.red   = pixel.in_red;
    in_pix.green = pixel.in_green;
    in_pix.blue  = pixel.in_blue;
  end

  rgbc_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .pix       (in_pix),
    .geo_clear (geo_clear),
    .w_last    (w_last),
    .h_last    (h_last),
    .s1_ctl    (s1_ctl),
    .win       (win),
    .win_ctl   (win_ctl),
    .win_tag   (win_tag)
  );

  rgbc_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .ksel      (kernel_select),
    .win       (win),
    .win_ctl   (win_ctl),
    .win_tag   (win_tag),
    .sum_res   (sum_res),
    .push      (push),
    .push_data (push_data)
  );

  rgbc_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (push_data),
    .pop      (pop),
    .rdata    (q_data),
    .nonempty (q_nonempty),
    .count    (q_count)
  );

  // Drive the result channel from the queue head
  assign pop               = q_nonempty && result.ready;
  assign result.valid      = q_nonempty;
  assign result.out_red    = q_data.pix.red;
  assign result.out_green  = q_data.pix.green;
  assign result.out_blue   = q_data.pix.blue;
  assign result.out_col    = q_data.tag.col;
  assign result.out_row    = q_data.tag.row;
  assign result.frame_last = q_data.tag.last;

  // Queued plus in-flight results never exceed the queue depth
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= SUM_W'(OUT_DEPTH))
    else $error("result credits exceed queue depth");

endmodule
